// ----- rtl/bmm_pkg.sv -----
// Shared types, constants and the microcode program of the bipartite matching core.
`default_nettype none

package bmm_pkg;

    // Microcode step address width and type.
    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] upc_t;

    // Configuration register reset values.
    localparam logic [5:0] RIGHT_COUNT_RST = 6'd32;
    localparam logic [5:0] LEFT_COUNT_RST  = 6'd32;

    // Input command codes.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Step addresses of the microcode program.
    localparam upc_t ST_IDLE   = 4'd0;
    localparam upc_t ST_UBEGIN = 4'd1;
    localparam upc_t ST_PUSH0  = 4'd2;
    localparam upc_t ST_FETCH  = 4'd3;
    localparam upc_t ST_SCAN   = 4'd4;
    localparam upc_t ST_CHKM   = 4'd5;
    localparam upc_t ST_PUSH   = 4'd6;
    localparam upc_t ST_UNWIND = 4'd7;
    localparam upc_t ST_SUCC   = 4'd8;
    localparam upc_t ST_POPCHK = 4'd9;
    localparam upc_t ST_FAIL   = 4'd10;
    localparam upc_t ST_EINIT  = 4'd11;
    localparam upc_t ST_EMIT   = 4'd12;
    localparam upc_t ST_DONE   = 4'd13;

    // Datapath operations selected by a control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_IDLE,
        OP_PUSH0,
        OP_FETCH,
        OP_SCAN,
        OP_PUSH,
        OP_UNWIND,
        OP_SUCC,
        OP_NEXTU,
        OP_EINIT,
        OP_EMIT
    } uop_t;

    // Jump conditions selected by a control word.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_START,
        C_U_DONE,
        C_NOT_FOUND,
        C_ROW_FREE,
        C_DEPTH_GT1,
        C_DEPTH_NZ,
        C_EMIT_MORE,
        C_RC_ZERO
    } cond_t;

    // One control word: datapath operation, jump condition and jump target.
    typedef struct packed {
        uop_t  op;
        cond_t cond;
        upc_t  target;
    } uword_t;

    // Status flags the datapath reports to the sequencer.
    typedef struct packed {
        logic start_acc;
        logic u_done;
        logic not_found;
        logic row_free;
        logic depth_gt1;
        logic depth_nz;
        logic emit_more;
        logic rc_zero;
    } dp_status_t;

    // Read-only control store. Without a jump, the step counter advances by one.
    function automatic uword_t ucode_rom(input upc_t addr);
        uword_t w;
        unique case (addr)
            ST_IDLE:   w = '{op: OP_IDLE,   cond: C_NOT_START, target: ST_IDLE};
            ST_UBEGIN: w = '{op: OP_NOP,    cond: C_U_DONE,    target: ST_EINIT};
            ST_PUSH0:  w = '{op: OP_PUSH0,  cond: C_NEVER,     target: ST_IDLE};
            ST_FETCH:  w = '{op: OP_FETCH,  cond: C_NEVER,     target: ST_IDLE};
            ST_SCAN:   w = '{op: OP_SCAN,   cond: C_NOT_FOUND, target: ST_POPCHK};
            ST_CHKM:   w = '{op: OP_NOP,    cond: C_ROW_FREE,  target: ST_UNWIND};
            ST_PUSH:   w = '{op: OP_PUSH,   cond: C_ALWAYS,    target: ST_FETCH};
            ST_UNWIND: w = '{op: OP_UNWIND, cond: C_DEPTH_GT1, target: ST_UNWIND};
            ST_SUCC:   w = '{op: OP_SUCC,   cond: C_ALWAYS,    target: ST_UBEGIN};
            ST_POPCHK: w = '{op: OP_NOP,    cond: C_DEPTH_NZ,  target: ST_FETCH};
            ST_FAIL:   w = '{op: OP_NEXTU,  cond: C_ALWAYS,    target: ST_UBEGIN};
            ST_EINIT:  w = '{op: OP_EINIT,  cond: C_RC_ZERO,   target: ST_IDLE};
            ST_EMIT:   w = '{op: OP_EMIT,   cond: C_EMIT_MORE, target: ST_EMIT};
            ST_DONE:   w = '{op: OP_NOP,    cond: C_ALWAYS,    target: ST_IDLE};
            default:   w = '{op: OP_NOP,    cond: C_ALWAYS,    target: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bmm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/bmm_sequencer.sv -----
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none

module bmm_sequencer (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire bmm_pkg::dp_status_t status,
    output bmm_pkg::uword_t          uword
);

    bmm_pkg::upc_t upc_reg;
    bmm_pkg::upc_t upc_next;
    logic          jump;

    // The current control word comes straight from the control store.
    assign uword = bmm_pkg::ucode_rom(upc_reg);

    // Condition select and next step.
    always_comb begin
        unique case (uword.cond)
            bmm_pkg::C_NEVER:     jump = 1'b0;
            bmm_pkg::C_ALWAYS:    jump = 1'b1;
            bmm_pkg::C_NOT_START: jump = !status.start_acc;
            bmm_pkg::C_U_DONE:    jump = status.u_done;
            bmm_pkg::C_NOT_FOUND: jump = status.not_found;
            bmm_pkg::C_ROW_FREE:  jump = status.row_free;
            bmm_pkg::C_DEPTH_GT1: jump = status.depth_gt1;
            bmm_pkg::C_DEPTH_NZ:  jump = status.depth_nz;
            bmm_pkg::C_EMIT_MORE: jump = status.emit_more;
            bmm_pkg::C_RC_ZERO:   jump = status.rc_zero;
            default:              jump = 1'b1;
        endcase
        upc_next = jump ? uword.target : upc_reg + bmm_pkg::upc_t'(1);
    end

    // Step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= bmm_pkg::ST_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

    // The program never runs past its final step.
    a_upc_in_program: assert property (@(posedge aclk) disable iff (!aresetn)
        upc_reg <= bmm_pkg::ST_DONE)
        else $error("microcode step counter left the program");

endmodule

`default_nettype wire

// ----- rtl/bmm_datapath.sv -----
// Matching datapath: adjacency store, search stack, match table and result register.
`default_nettype none

module bmm_datapath #(
    parameter int MAX_RIGHT = 32,
    parameter int MAX_LEFT  = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire bmm_pkg::uword_t     uword,
    input  wire logic                in_acc,
    input  wire logic                s_command,
    input  wire logic [4:0]          s_left_vertex,
    input  wire logic [31:0]         s_adjacency_mask,
    input  wire logic [5:0]          right_count,
    input  wire logic [5:0]          left_count,
    input  wire logic                m_ready,
    output logic                     m_valid,
    output logic [4:0]               m_right_vertex,
    output logic                     m_is_matched,
    output logic [4:0]               m_matched_left,
    output logic [5:0]               m_match_total,
    output logic                     m_last,
    output bmm_pkg::dp_status_t      status
);

    localparam int ER  = (MAX_RIGHT < 32) ? MAX_RIGHT : 32;
    localparam int RW  = $clog2(ER);
    localparam int CW  = $clog2(ER + 1);
    localparam int LW  = $clog2(MAX_LEFT);
    localparam int LCW = $clog2(MAX_LEFT + 1);

    typedef struct packed {
        logic [LW-1:0] lv;
        logic [CW-1:0] nxt;
        logic [RW-1:0] row;
    } frame_t;

    // Control registers.
    logic [CW-1:0]       rc_reg, rc_next;
    logic [LCW-1:0]      lc_reg, lc_next;
    logic [LCW-1:0]      u_reg, u_next;
    logic [CW-1:0]       depth_reg, depth_next;
    logic [ER-1:0]       visited_reg, visited_next;
    logic [CW-1:0]       cur_next_reg, cur_next_next;
    logic [RW-1:0]       r_reg, r_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [RW-1:0]       rout_reg, rout_next;
    logic                m_valid_reg, m_valid_next;
    logic                adj_vld_reg;
    logic [MAX_LEFT-1:0] adj_valid_reg;
    logic [ER-1:0]       mvalid_reg;

    // Payload storage.
    logic [LW-1:0]       mtab_reg [ER];
    frame_t              stack_reg [ER];
    logic [4:0]          m_right_vertex_reg;
    logic                m_is_matched_reg;
    logic [4:0]          m_matched_left_reg;
    logic [5:0]          m_match_total_reg;
    logic                m_last_reg;

    // Combinational helpers.
    logic                load_acc, start_acc, load_in_range;
    logic [LW-1:0]       load_addr;
    logic [CW-1:0]       depth_m1;
    logic [RW-1:0]       top_idx, push_idx;
    frame_t              top_frame;
    logic [31:0]         adj_rdata;
    logic [31:0]         mask_eff;
    logic [ER-1:0]       cand;
    logic                found;
    logic [RW-1:0]       fidx;
    logic [RW-1:0]       mt_raddr;
    logic [LW-1:0]       mtab_rd;
    logic                mv_rd;
    logic                load_ok, last_now;
    logic [CW-1:0]       rc_eff;
    logic [LCW-1:0]      lc_eff;

    // Input item decode.
    assign load_acc      = in_acc && (s_command == bmm_pkg::CMD_LOAD);
    assign start_acc     = in_acc && (s_command == bmm_pkg::CMD_START);
    assign load_in_range = ({27'd0, s_left_vertex} < 32'(MAX_LEFT));
    assign load_addr     = LW'(s_left_vertex);

    // Saturated counts latched at a start transfer.
    assign rc_eff = (int'(right_count) < ER) ? CW'(right_count) : CW'(ER);
    assign lc_eff = (int'(left_count) < MAX_LEFT) ? LCW'(left_count) : LCW'(MAX_LEFT);

    // Top of the search stack.
    assign depth_m1  = depth_reg - CW'(1);
    assign top_idx   = depth_m1[RW-1:0];
    assign push_idx  = depth_reg[RW-1:0];
    assign top_frame = stack_reg[top_idx];

    // Adjacency store; rows never loaded since reset read as no edges.
    bmm_ram #(
        .WIDTH (32),
        .DEPTH (MAX_LEFT)
    ) u_adj_ram (
        .clk   (aclk),
        .we    (load_acc && load_in_range),
        .waddr (load_addr),
        .wdata (s_adjacency_mask),
        .re    (uword.op == bmm_pkg::OP_FETCH),
        .raddr (top_frame.lv),
        .rdata (adj_rdata)
    );

    assign mask_eff = adj_vld_reg ? adj_rdata : 32'd0;

    // Candidate rows: an edge, not visited in this attempt, at or past the resume
    // point, and inside the right count. The lowest candidate wins.
    always_comb begin
        found = 1'b0;
        fidx  = '0;
        for (int i = 0; i < ER; i++) begin
            cand[i] = mask_eff[i] && !visited_reg[i] &&
                      (CW'(i) >= cur_next_reg) && (CW'(i) < rc_reg);
        end
        for (int i = ER - 1; i >= 0; i--) begin
            if (cand[i]) begin
                found = 1'b1;
                fidx  = RW'(i);
            end
        end
    end

    // Match table read port, shared by the search and result emission.
    assign mt_raddr = (uword.op == bmm_pkg::OP_EMIT) ? rout_reg : r_reg;
    assign mtab_rd  = mtab_reg[mt_raddr];
    assign mv_rd    = mvalid_reg[mt_raddr];

    // Result register handshake.
    assign load_ok  = !m_valid_reg || m_ready;
    assign last_now = ((CW'(rout_reg) + CW'(1)) == rc_reg);

    // Status toward the sequencer.
    assign status.start_acc = start_acc;
    assign status.u_done    = (u_reg >= lc_reg) || (rc_reg == '0);
    assign status.not_found = !found;
    assign status.row_free  = !mv_rd;
    assign status.depth_gt1 = (depth_reg > CW'(1));
    assign status.depth_nz  = (depth_reg != '0);
    assign status.emit_more = !(load_ok && last_now);
    assign status.rc_zero   = (rc_reg == '0);

    // Next values of the control registers.
    always_comb begin
        rc_next       = rc_reg;
        lc_next       = lc_reg;
        u_next        = u_reg;
        depth_next    = depth_reg;
        visited_next  = visited_reg;
        cur_next_next = cur_next_reg;
        r_next        = r_reg;
        count_next    = count_reg;
        rout_next     = rout_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        unique case (uword.op)
            bmm_pkg::OP_IDLE: begin
                if (start_acc) begin
                    rc_next    = rc_eff;
                    lc_next    = lc_eff;
                    u_next     = '0;
                    count_next = '0;
                end
            end
            bmm_pkg::OP_PUSH0: begin
                depth_next   = CW'(1);
                visited_next = '0;
            end
            bmm_pkg::OP_FETCH: begin
                cur_next_next = top_frame.nxt;
            end
            bmm_pkg::OP_SCAN: begin
                if (found) begin
                    visited_next[fidx] = 1'b1;
                    r_next             = fidx;
                end else begin
                    depth_next = depth_m1;
                end
            end
            bmm_pkg::OP_PUSH: begin
                depth_next = depth_reg + CW'(1);
            end
            bmm_pkg::OP_UNWIND: begin
                depth_next = depth_m1;
            end
            bmm_pkg::OP_SUCC: begin
                count_next = count_reg + CW'(1);
                u_next     = u_reg + LCW'(1);
            end
            bmm_pkg::OP_NEXTU: begin
                u_next = u_reg + LCW'(1);
            end
            bmm_pkg::OP_EINIT: begin
                rout_next = '0;
            end
            bmm_pkg::OP_EMIT: begin
                if (load_ok) begin
                    m_valid_next = 1'b1;
                    rout_next    = rout_reg + RW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Control register update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rc_reg       <= '0;
            lc_reg       <= '0;
            u_reg        <= '0;
            depth_reg    <= '0;
            visited_reg  <= '0;
            cur_next_reg <= '0;
            r_reg        <= '0;
            count_reg    <= '0;
            rout_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            rc_reg       <= rc_next;
            lc_reg       <= lc_next;
            u_reg        <= u_next;
            depth_reg    <= depth_next;
            visited_reg  <= visited_next;
            cur_next_reg <= cur_next_next;
            r_reg        <= r_next;
            count_reg    <= count_next;
            rout_reg     <= rout_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Adjacency row valid bits; a row reads as empty until it is loaded.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adj_valid_reg <= '0;
            adj_vld_reg   <= 1'b0;
        end else begin
            if (load_acc && load_in_range) begin
                adj_valid_reg[load_addr] <= 1'b1;
            end
            if (uword.op == bmm_pkg::OP_FETCH) begin
                adj_vld_reg <= adj_valid_reg[top_frame.lv];
            end
        end
    end

    // Match valid bits: cleared by a start transfer, set while an augmenting
    // path is written back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= '0;
        end else if (start_acc) begin
            mvalid_reg <= '0;
        end else if (uword.op == bmm_pkg::OP_UNWIND) begin
            mvalid_reg[top_frame.row] <= 1'b1;
        end
    end

    // Match table entries along the augmenting path.
    always_ff @(posedge aclk) begin
        if (uword.op == bmm_pkg::OP_UNWIND) begin
            mtab_reg[top_frame.row] <= top_frame.lv;
        end
    end

    // Search stack frames.
    always_ff @(posedge aclk) begin
        unique case (uword.op)
            bmm_pkg::OP_PUSH0: begin
                stack_reg[0] <= '{lv: LW'(u_reg), nxt: '0, row: '0};
            end
            bmm_pkg::OP_SCAN: begin
                if (found) begin
                    stack_reg[top_idx].nxt <= CW'(fidx) + CW'(1);
                    stack_reg[top_idx].row <= fidx;
                end
            end
            bmm_pkg::OP_PUSH: begin
                // A frame past the deepest slot sees every row visited and only
                // pops, so it needs no storage.
                if (depth_reg < CW'(ER)) begin
                    stack_reg[push_idx] <= '{lv: mtab_rd, nxt: '0, row: '0};
                end
            end
            default: begin
            end
        endcase
    end

    // Result payload, loaded when the output register is free or being drained.
    always_ff @(posedge aclk) begin
        if ((uword.op == bmm_pkg::OP_EMIT) && load_ok) begin
            m_right_vertex_reg <= 5'(rout_reg);
            m_is_matched_reg   <= mv_rd;
            m_matched_left_reg <= mv_rd ? 5'(mtab_rd) : 5'd0;
            m_match_total_reg  <= 6'(count_reg);
            m_last_reg         <= last_now;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_right_vertex = m_right_vertex_reg;
    assign m_is_matched   = m_is_matched_reg;
    assign m_matched_left = m_matched_left_reg;
    assign m_match_total  = m_match_total_reg;
    assign m_last         = m_last_reg;

    // Every frame on the stack holds its own matched row, so a push never starts
    // from a depth above the right count.
    a_push_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (uword.op == bmm_pkg::OP_PUSH) |-> (depth_reg <= rc_reg))
        else $error("search stack pushed beyond the right count");

    // Before emission the matched rows agree with the match count.
    a_count_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (uword.op == bmm_pkg::OP_EINIT) |-> ($countones(mvalid_reg) == int'(count_reg)))
        else $error("match count differs from matched rows");

endmodule

`default_nettype wire

// ----- rtl/bipartite_max_matching_core.sv -----
// Top level of the bipartite maximum matching core: configuration port and block wiring.
//
//   Channel | Direction | Handshake         | Payload
//   s_      | in        | s_valid/s_ready   | command, left_vertex, adjacency_mask
//   m_      | out       | m_valid/m_ready   | right_vertex, is_matched, matched_left,
//           |           |                   | match_total, last
//   APB     | in/out    | psel/penable      | right_count (0x0), left_count (0x4)
//
// Loads can follow each other every cycle. A start runs the search: it opens each left
// vertex, pushes frames and backtracks; a success writes back the path rows, a failure
// moves to the next left vertex. Emission runs a setup step, then one result per cycle
// over the right count while the result register is free or being drained, then returns
// to idle. Reset is synchronous and marks every adjacency row and match entry invalid.
// A stalled result holds the emit step; input waits until the last result is registered.
`default_nettype none

module bipartite_max_matching_core #(
    parameter int MAX_RIGHT = 32,
    parameter int MAX_LEFT  = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Input channel.
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_command,
    input  wire logic [4:0]  s_left_vertex,
    input  wire logic [31:0] s_adjacency_mask,
    // Result channel.
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [4:0]       m_right_vertex,
    output logic             m_is_matched,
    output logic [4:0]       m_matched_left,
    output logic [5:0]       m_match_total,
    output logic             m_last
);

    localparam logic REG_RIGHT_COUNT = 1'b0;
    localparam logic REG_LEFT_COUNT  = 1'b1;

    logic [5:0]          right_count_reg, right_count_next;
    logic [5:0]          left_count_reg, left_count_next;
    logic                cfg_wr;
    logic                in_acc;
    bmm_pkg::uword_t     uword;
    bmm_pkg::dp_status_t status;

    // Configuration registers, written on the access cycle of a write transfer.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        right_count_next = right_count_reg;
        left_count_next  = left_count_reg;
        if (cfg_wr) begin
            unique case (paddr[2])
                REG_RIGHT_COUNT: right_count_next = pwdata[5:0];
                REG_LEFT_COUNT:  left_count_next  = pwdata[5:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            right_count_reg <= bmm_pkg::RIGHT_COUNT_RST;
            left_count_reg  <= bmm_pkg::LEFT_COUNT_RST;
        end else begin
            right_count_reg <= right_count_next;
            left_count_reg  <= left_count_next;
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[2])
            REG_RIGHT_COUNT: prdata = {26'd0, right_count_reg};
            REG_LEFT_COUNT:  prdata = {26'd0, left_count_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // Input transfers are taken only in the idle step of the program.
    assign s_ready = (uword.op == bmm_pkg::OP_IDLE);
    assign in_acc  = s_valid && s_ready;

    bmm_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .uword   (uword)
    );

    bmm_datapath #(
        .MAX_RIGHT (MAX_RIGHT),
        .MAX_LEFT  (MAX_LEFT)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .uword            (uword),
        .in_acc           (in_acc),
        .s_command        (s_command),
        .s_left_vertex    (s_left_vertex),
        .s_adjacency_mask (s_adjacency_mask),
        .right_count      (right_count_reg),
        .left_count       (left_count_reg),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_right_vertex   (m_right_vertex),
        .m_is_matched     (m_is_matched),
        .m_matched_left   (m_matched_left),
        .m_match_total    (m_match_total),
        .m_last           (m_last),
        .status           (status)
    );

    // A start transfer always leaves the idle step for the search.
    a_start_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_command == bmm_pkg::CMD_START)) |=> !s_ready)
        else $error("input still accepted after a start transfer");

endmodule

`default_nettype wire

// ----- tb/bipartite_max_matching_core_test.sv -----
// Self-checking testbench for the bipartite maximum matching core.
module bipartite_max_matching_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Configuration register addresses.
    localparam logic [2:0] REG_RIGHT_COUNT = 3'd0;
    localparam logic [2:0] REG_LEFT_COUNT  = 3'd4;

    localparam int VERTEX_LIMIT = 32;
    localparam int ITEM_TARGET  = 230;
    localparam int SETTLE_CYCLES = 400;
    localparam int REPORT_LIMIT = 10;

    // One result transfer as seen on the result channel.
    typedef struct packed {
        logic [4:0] right_vertex;
        logic       is_matched;
        logic [4:0] matched_left;
        logic [5:0] match_total;
        logic       last;
    } match_report_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_command = bmm_pkg::CMD_LOAD;
    logic [4:0]  s_left_vertex = '0;
    logic [31:0] s_adjacency_mask = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [4:0]  m_right_vertex;
    logic        m_is_matched;
    logic [4:0]  m_matched_left;
    logic [5:0]  m_match_total;
    logic        m_last;

    // Mirror of the block's state used to predict each match report.
    logic [31:0] graph_rows [0:VERTEX_LIMIT-1];
    int          row_owner [0:VERTEX_LIMIT-1];
    logic [31:0] row_taken;
    logic [31:0] seen_rows;
    int          path_left [0:VERTEX_LIMIT];
    int          path_next [0:VERTEX_LIMIT];
    int          path_row [0:VERTEX_LIMIT];
    logic [5:0]  right_cfg = bmm_pkg::RIGHT_COUNT_RST;
    logic [5:0]  left_cfg = bmm_pkg::LEFT_COUNT_RST;

    match_report_t expected_reports[$];
    int            mismatches = 0;
    int            items_sent = 0;
    bit            steady_flow = 1'b0;

    bipartite_max_matching_core DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_left_vertex    (s_left_vertex),
        .s_adjacency_mask (s_adjacency_mask),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_right_vertex   (m_right_vertex),
        .m_is_matched     (m_is_matched),
        .m_matched_left   (m_matched_left),
        .m_match_total    (m_match_total),
        .m_last           (m_last)
    );

    always #4 aclk = ~aclk;

    // The result side stalls at random except during the steady stretch.
    always @(negedge aclk) begin
        m_ready <= steady_flow || ($urandom_range(99) >= 23);
    end

    // Counts above the vertex limit saturate.
    function automatic int effective_count(input logic [5:0] count);
        return (count > VERTEX_LIMIT) ? VERTEX_LIMIT : int'(count);
    endfunction

    // One augmenting-path search from a left vertex, with an explicit path stack.
    function automatic bit augment_from(input int start, input int rc);
        int          depth;
        int          top;
        int          r;
        int          k;
        logic [31:0] edges;
        bit          grown;
        depth = 1;
        path_left[0] = start;
        path_next[0] = 0;
        path_row[0] = 0;
        seen_rows = '0;
        grown = 1'b0;
        while (depth > 0 && !grown) begin
            top = depth - 1;
            edges = graph_rows[path_left[top] % VERTEX_LIMIT];
            r = path_next[top];
            while (r < rc && (seen_rows[r] || !edges[r])) r++;
            if (r >= rc) begin
                depth--;
            end else begin
                seen_rows[r] = 1'b1;
                path_next[top] = r + 1;
                path_row[top] = r;
                if (!row_taken[r]) begin
                    // A free row ends the path: flip every pairing along it.
                    for (k = depth; k > 0; k--) begin
                        row_owner[path_row[k-1]] = path_left[k-1];
                        row_taken[path_row[k-1]] = 1'b1;
                    end
                    grown = 1'b1;
                end else if (depth > VERTEX_LIMIT) begin
                    depth--;
                end else begin
                    path_left[depth] = row_owner[r];
                    path_next[depth] = 0;
                    path_row[depth] = 0;
                    depth++;
                end
            end
        end
        return grown;
    endfunction

    // Runs the full matching and queues one report per right vertex in use.
    function automatic void predict_matching();
        int            rc;
        int            lc;
        int            total;
        int            r;
        match_report_t rep;
        rc = effective_count(right_cfg);
        lc = effective_count(left_cfg);
        row_taken = '0;
        for (r = 0; r < VERTEX_LIMIT; r++) row_owner[r] = 0;
        total = 0;
        if (rc > 0) begin
            for (int u = 0; u < lc; u++) begin
                if (augment_from(u, rc)) total++;
            end
        end
        for (r = 0; r < rc; r++) begin
            rep.right_vertex = r[4:0];
            rep.is_matched   = row_taken[r];
            rep.matched_left = row_taken[r] ? row_owner[r][4:0] : 5'd0;
            rep.match_total  = total[5:0];
            rep.last         = (r + 1 == rc);
            expected_reports.push_back(rep);
        end
    endfunction

    // Random adjacency masks of varied density.
    function automatic logic [31:0] random_mask();
        logic [31:0] mask;
        case ($urandom_range(5))
            0: mask = '1;
            1: mask = '0;
            2: mask = 32'd1 << $urandom_range(31);
            3: mask = $urandom & $urandom;
            4: mask = $urandom & $urandom & $urandom;
            default: mask = $urandom;
        endcase
        return mask;
    endfunction

    // Mostly small vertex counts, with zero and the saturating range now and then.
    function automatic logic [5:0] pick_count();
        logic [5:0] count;
        case ($urandom_range(9))
            0: count = 6'd0;
            1: count = 6'($urandom_range(63, 33));
            2: count = 6'd32;
            default: count = 6'($urandom_range(8, 1));
        endcase
        return count;
    endfunction

    // Sends one item, with random gaps, and updates the prediction on its transfer.
    task automatic send_item(input logic cmd, input logic [4:0] vertex,
                             input logic [31:0] mask);
        while (!steady_flow && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_left_vertex <= vertex;
        s_adjacency_mask <= mask;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (cmd == bmm_pkg::CMD_LOAD) begin
            graph_rows[vertex] = mask;
        end else begin
            predict_matching();
        end
        items_sent++;
        @(negedge aclk);
    endtask

    // Holds the input off until every expected report is back and the block settles.
    task automatic drain_reports();
        s_valid <= 1'b0;
        while (expected_reports.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Two-phase register write; upper data bits are don't-care noise.
    // The register is read back once the write has landed.
    task automatic apb_write(input logic [2:0] addr, input logic [5:0] value);
        logic [31:0] word;
        word = $urandom;
        word[5:0] = value;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= word;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (addr == REG_RIGHT_COUNT) right_cfg = value;
        else left_cfg = value;
        @(negedge aclk);
        if (prdata !== {26'd0, value}) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("register read-back at %0d: expected %0d actual %0d",
                         addr, value, prdata);
            end
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_counts(input logic [5:0] rights, input logic [5:0] lefts);
        drain_reports();
        apb_write(REG_RIGHT_COUNT, rights);
        apb_write(REG_LEFT_COUNT, lefts);
    endtask

    // An empty graph right after reset: every row unmatched.
    task automatic test_reset_defaults();
        send_item(bmm_pkg::CMD_START, 5'd0, 32'd0);
    endtask

    // Extreme vertex indexes and masks.
    task automatic test_field_extremes();
        send_item(bmm_pkg::CMD_LOAD, 5'd0, 32'hFFFF_FFFF);
        send_item(bmm_pkg::CMD_LOAD, 5'd31, 32'h8000_0000);
        send_item(bmm_pkg::CMD_LOAD, 5'd1, 32'h0000_0001);
        send_item(bmm_pkg::CMD_START, 5'd31, 32'hFFFF_FFFF);
    endtask

    // Zero and saturated counts, and edges that fall beyond the right count.
    task automatic test_count_limits();
        set_counts(6'd0, 6'd32);
        send_item(bmm_pkg::CMD_START, 5'd0, 32'd0);
        set_counts(6'd63, 6'd0);
        send_item(bmm_pkg::CMD_START, 5'd0, 32'd0);
        set_counts(6'd5, 6'd63);
        send_item(bmm_pkg::CMD_LOAD, 5'd2, 32'hFFFF_FFE0);
        send_item(bmm_pkg::CMD_START, 5'd0, 32'd0);
        set_counts(6'd1, 6'd1);
        send_item(bmm_pkg::CMD_START, 5'd0, 32'd0);
    endtask

    // A graph that forces rematching along multi-level alternating paths.
    task automatic test_augmenting_paths();
        set_counts(6'd4, 6'd4);
        send_item(bmm_pkg::CMD_LOAD, 5'd0, 32'h0000_0003);
        send_item(bmm_pkg::CMD_LOAD, 5'd1, 32'h0000_0001);
        send_item(bmm_pkg::CMD_LOAD, 5'd2, 32'h0000_0006);
        send_item(bmm_pkg::CMD_LOAD, 5'd3, 32'h0000_0004);
        send_item(bmm_pkg::CMD_START, 5'd0, 32'd0);
    endtask

    // Random graphs under random counts: load a set of rows, then match; now and then send stray commands.
    task automatic test_random_graphs();
        int         n;
        int         lc;
        logic [4:0] vertex;
        while (items_sent < ITEM_TARGET) begin
            steady_flow = (items_sent >= 100 && items_sent < 150);
            if ($urandom_range(3) == 0) begin
                set_counts(pick_count(), pick_count());
            end
            if ($urandom_range(9) == 0) begin
                // Stray commands with no well-formed load sequence.
                repeat ($urandom_range(4, 1)) begin
                    send_item($urandom_range(1) ? bmm_pkg::CMD_START : bmm_pkg::CMD_LOAD,
                              5'($urandom_range(31)), random_mask());
                end
            end else begin
                lc = effective_count(left_cfg);
                n = $urandom_range(lc);
                for (int i = 0; i < n; i++) begin
                    vertex = ($urandom_range(9) < 8) ? i[4:0] : 5'($urandom_range(31));
                    send_item(bmm_pkg::CMD_LOAD, vertex, random_mask());
                end
                send_item(bmm_pkg::CMD_START, 5'($urandom_range(31)), $urandom);
            end
        end
        steady_flow = 1'b0;
    endtask

    // Compares every result transfer with the oldest expected report.
    always @(posedge aclk) begin
        match_report_t got;
        match_report_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            got = '{m_right_vertex, m_is_matched, m_matched_left, m_match_total, m_last};
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected transfer: row=%0d matched=%0d left=%0d total=%0d last=%0d",
                             got.right_vertex, got.is_matched, got.matched_left,
                             got.match_total, got.last);
                end
            end else begin
                want = expected_reports.pop_front();
                if (got.right_vertex !== want.right_vertex ||
                    got.is_matched !== want.is_matched ||
                    got.matched_left !== want.matched_left ||
                    got.match_total !== want.match_total ||
                    got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("mismatch: expected row=%0d matched=%0d left=%0d total=%0d last=%0d",
                                 want.right_vertex, want.is_matched, want.matched_left,
                                 want.match_total, want.last);
                        $display("          actual   row=%0d matched=%0d left=%0d total=%0d last=%0d",
                                 got.right_vertex, got.is_matched, got.matched_left,
                                 got.match_total, got.last);
                    end
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < VERTEX_LIMIT; i++) graph_rows[i] = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_defaults();
        test_field_extremes();
        test_count_limits();
        test_augmenting_paths();
        test_random_graphs();
        drain_reports();
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #50_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
